/* src/icc_pkg.sv */
// shared types, codes and character helpers for the identifier case convention checker
package icc_pkg;

  localparam int unsigned CONV_W = 4;
  localparam int unsigned CH_W   = 8;

  localparam logic [CONV_W-1:0] CONV_NONE      = 4'd0;
  localparam logic [CONV_W-1:0] CONV_LOWER     = 4'd1;
  localparam logic [CONV_W-1:0] CONV_UPPER     = 4'd2;
  localparam logic [CONV_W-1:0] CONV_CAMEL     = 4'd3;
  localparam logic [CONV_W-1:0] CONV_PASCAL    = 4'd4;
  localparam logic [CONV_W-1:0] CONV_SNAKE     = 4'd5;
  localparam logic [CONV_W-1:0] CONV_LEAD_SNK  = 4'd6;
  localparam logic [CONV_W-1:0] CONV_UPPER_SNK = 4'd7;
  localparam logic [CONV_W-1:0] CONV_SCREAM    = 4'd8;
  localparam logic [CONV_W-1:0] CONV_LISP      = 4'd9;

  localparam logic [2:0] RULE_LOWER  = 3'd0;
  localparam logic [2:0] RULE_UPPER  = 3'd1;
  localparam logic [2:0] RULE_CAP    = 3'd2;
  localparam logic [2:0] RULE_CAMEL  = 3'd3;
  localparam logic [2:0] RULE_PASCAL = 3'd4;

  localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CH_W-1:0] CH_HYPHEN     = 8'h2D;
  localparam logic [CH_W-1:0] CH_LO_A       = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z       = 8'h7A;
  localparam logic [CH_W-1:0] CH_UP_A       = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z       = 8'h5A;
  localparam logic [CH_W-1:0] CH_DIG_0      = 8'h30;
  localparam logic [CH_W-1:0] CH_DIG_9      = 8'h39;

  typedef struct packed {
    logic at_word_start;
    logic in_first_word;
    logic word_has_letter;
    logic word_all_digits;
    logic word_head_ok;
    logic word_tail_ok;
    logic name_ok;
  } chk_state_t;

  localparam chk_state_t STATE_RESET = '{
    at_word_start:   1'b1,
    in_first_word:   1'b1,
    word_has_letter: 1'b0,
    word_all_digits: 1'b1,
    word_head_ok:    1'b0,
    word_tail_ok:    1'b1,
    name_ok:         1'b1
  };

  function automatic logic is_lo(input logic [CH_W-1:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  function automatic logic is_up(input logic [CH_W-1:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic is_dig(input logic [CH_W-1:0] c);
    return (c >= CH_DIG_0) && (c <= CH_DIG_9);
  endfunction

endpackage

/* src/icc_step.sv */
// per-item state update and verdict logic for the identifier checker
module icc_step (
  input  logic [icc_pkg::CONV_W-1:0] conv,
  input  logic [icc_pkg::CH_W-1:0]   ch,
  input  logic                       has_char,
  input  logic                       last,
  input  icc_pkg::chk_state_t        st,
  output icc_pkg::chk_state_t        st_nxt,
  output logic                       verdict
);
  import icc_pkg::*;

  logic       sep_us;
  logic       sep_hy;
  logic       is_sep;
  logic       bypass;
  logic [2:0] rule;
  logic       head_fit;
  logic       tail_fit;
  logic       c_lo;
  logic       c_up;
  logic       c_dig;
  logic       wp_cur;
  logic       wp_upd;
  chk_state_t st_upd;

  assign c_lo  = is_lo(ch);
  assign c_up  = is_up(ch);
  assign c_dig = is_dig(ch);

  assign sep_us = (conv >= CONV_SNAKE) && (conv <= CONV_SCREAM) && (ch == CH_UNDERSCORE);
  assign sep_hy = (conv == CONV_LISP) && (ch == CH_HYPHEN);
  assign is_sep = sep_us || sep_hy;
  assign bypass = (conv != CONV_CAMEL) && (conv != CONV_PASCAL);

  always_comb begin
    case (conv)
      CONV_UPPER:     rule = RULE_UPPER;
      CONV_CAMEL:     rule = RULE_CAMEL;
      CONV_PASCAL:    rule = RULE_PASCAL;
      CONV_LEAD_SNK:  rule = st.in_first_word ? RULE_CAP : RULE_LOWER;
      CONV_UPPER_SNK: rule = RULE_CAP;
      CONV_SCREAM:    rule = RULE_UPPER;
      default:        rule = RULE_LOWER;
    endcase
  end

  always_comb begin
    case (rule)
      RULE_LOWER, RULE_CAMEL: head_fit = c_lo;
      default:                head_fit = c_up;
    endcase
    case (rule)
      RULE_UPPER:              tail_fit = c_up || c_dig;
      RULE_CAMEL, RULE_PASCAL: tail_fit = c_lo || c_up || c_dig;
      default:                 tail_fit = c_lo || c_dig;
    endcase
  end

  // word check on the state before this item (for separators)
  always_comb begin
    if (st.at_word_start) begin
      wp_cur = 1'b0;
    end else if (bypass && !st.word_has_letter) begin
      wp_cur = st.word_all_digits;
    end else begin
      wp_cur = st.word_head_ok && st.word_tail_ok;
    end
  end

  always_comb begin
    st_upd = st;
    if (has_char) begin
      if (is_sep) begin
        st_upd                 = STATE_RESET;
        st_upd.name_ok         = st.name_ok && wp_cur;
        st_upd.in_first_word   = 1'b0;
      end else begin
        if (st.at_word_start) begin
          st_upd.word_head_ok = head_fit;
        end else begin
          st_upd.word_tail_ok = st.word_tail_ok && tail_fit;
        end
        st_upd.word_has_letter = st.word_has_letter || c_lo || c_up;
        st_upd.word_all_digits = st.word_all_digits && c_dig;
        st_upd.at_word_start   = 1'b0;
      end
    end
  end

  // word check on the updated state (for the verdict)
  always_comb begin
    if (st_upd.at_word_start) begin
      wp_upd = 1'b0;
    end else if (bypass && !st_upd.word_has_letter) begin
      wp_upd = st_upd.word_all_digits;
    end else begin
      wp_upd = st_upd.word_head_ok && st_upd.word_tail_ok;
    end
  end

  always_comb begin
    if (conv == CONV_NONE) begin
      verdict = 1'b1;
    end else if (conv > CONV_LISP) begin
      verdict = 1'b0;
    end else begin
      verdict = st_upd.name_ok && wp_upd;
    end
  end

  assign st_nxt = last ? STATE_RESET : st_upd;

endmodule

/* src/identifier_case_convention_check.sv */
// top level of the identifier case convention checker: input register, state and result register
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_ch, in_has_char, in_last
//   out     | output    | out_valid, out_ready, out_matches_res
//   cfg     | input     | cfg_valid, cfg_ready, cfg_convention
//
// one item per cycle unless a last item waits; a verdict is registered in the result register
// the input register and the state update feed the result register in one pass per item
// an item with last set waits in the input register while an earlier verdict is not taken
// synchronous active-low reset clears the state, the convention register and both valid flags
module identifier_case_convention_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [icc_pkg::CH_W-1:0]   in_ch,
  input  logic                       in_has_char,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_matches_res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [icc_pkg::CONV_W-1:0] cfg_convention
);
  import icc_pkg::*;

  logic [CONV_W-1:0] conv_val_r;
  logic              s1_valid_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_has_r;
  logic              s1_last_r;
  chk_state_t        st_r;
  chk_state_t        st_nxt;
  logic              verdict;
  logic              out_valid_r;
  logic              out_res_r;
  logic              out_free;
  logic              s1_fire;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready  = !s1_valid_r || s1_fire;

  assign out_valid       = out_valid_r;
  assign out_matches_res = out_res_r;

  // convention register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_val_r <= CONV_NONE;
    end else if (cfg_valid && cfg_ready) begin
      conv_val_r <= cfg_convention;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r   <= in_ch;
      s1_has_r  <= in_has_char;
      s1_last_r <= in_last;
    end
  end

  icc_step u_step (
    .conv     (conv_val_r),
    .ch       (s1_ch_r),
    .has_char (s1_has_r),
    .last     (s1_last_r),
    .st       (st_r),
    .st_nxt   (st_nxt),
    .verdict  (verdict)
  );

  // name and word state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_res_r <= verdict;
    end
  end

endmodule

/* sim/tb_identifier_case_convention_check.sv */
// testbench for the identifier case convention checker: directed and random names against a predictor
`timescale 1ns / 100ps

module tb_identifier_case_convention_check;
  import icc_pkg::*;

  localparam int ITEM_TARGET    = 750;
  localparam int PHASE_ITEMS    = 60;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    bit name_start;
    bit word_start;
    bit first_word;
    bit has_letter;
    bit all_digits;
    bit head_ok;
    bit tail_ok;
    bit name_ok;
  } scan_state_t;

  localparam scan_state_t SCAN_IDLE = '{
    name_start: 1'b1,
    word_start: 1'b1,
    first_word: 1'b1,
    has_letter: 1'b0,
    all_digits: 1'b1,
    head_ok:    1'b0,
    tail_ok:    1'b1,
    name_ok:    1'b1
  };

  typedef struct {
    logic [CH_W-1:0] ch;
    bit              has;
    bit              fin;
    int unsigned     gap;
  } char_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CH_W-1:0]   in_ch = '0;
  logic              in_has_char = 1'b0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_matches_res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CONV_W-1:0] cfg_convention = '0;

  char_item_t        char_q[$];
  bit                pending_verdicts[$];
  logic [CH_W-1:0]   name_buf[$];

  logic [CONV_W-1:0] conv_setting = CONV_NONE;
  scan_state_t       scan = SCAN_IDLE;

  int unsigned       send_gap_max = 0;
  int unsigned       recv_gap_max = 8;
  int                send_wait = 0;
  int                recv_wait = 0;
  int                rx_stall_count = 0;
  int                rx_stall_seen = 0;
  int                rx_stall_left = 0;
  int                stim_count = 0;
  int                chars_taken = 0;
  int                verdicts_seen = 0;
  int                mismatches = 0;
  int                idle_cycles = 0;

  bit                step_gives;
  bit                step_verdict;
  bit                expected_match;
  char_item_t        next_item;

  identifier_case_convention_check DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_has_char     (in_has_char),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_matches_res (out_matches_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_convention  (cfg_convention)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit lower_letter(input logic [CH_W-1:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  function automatic bit upper_letter(input logic [CH_W-1:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic bit decimal_digit(input logic [CH_W-1:0] c);
    return (c >= CH_DIG_0) && (c <= CH_DIG_9);
  endfunction

  function automatic bit splits(input logic [CONV_W-1:0] conv);
    return (conv >= CONV_SNAKE) && (conv <= CONV_LISP);
  endfunction

  function automatic logic [CH_W-1:0] sep_for(input logic [CONV_W-1:0] conv);
    return (conv == CONV_LISP) ? CH_HYPHEN : CH_UNDERSCORE;
  endfunction

  function automatic logic [2:0] rule_for(input logic [CONV_W-1:0] conv, input bit first);
    case (conv)
      CONV_UPPER:     return RULE_UPPER;
      CONV_CAMEL:     return RULE_CAMEL;
      CONV_PASCAL:    return RULE_PASCAL;
      CONV_LEAD_SNK:  return first ? RULE_CAP : RULE_LOWER;
      CONV_UPPER_SNK: return RULE_CAP;
      CONV_SCREAM:    return RULE_UPPER;
      default:        return RULE_LOWER;
    endcase
  endfunction

  function automatic bit head_fits(input logic [2:0] rule, input logic [CH_W-1:0] c);
    if (rule == RULE_LOWER || rule == RULE_CAMEL) begin
      return lower_letter(c);
    end
    return upper_letter(c);
  endfunction

  function automatic bit tail_fits(input logic [2:0] rule, input logic [CH_W-1:0] c);
    case (rule)
      RULE_UPPER:              return upper_letter(c) || decimal_digit(c);
      RULE_CAMEL, RULE_PASCAL: return lower_letter(c) || upper_letter(c) || decimal_digit(c);
      default:                 return lower_letter(c) || decimal_digit(c);
    endcase
  endfunction

  function automatic bit word_passes(input logic [CONV_W-1:0] conv);
    if (scan.word_start) begin
      return 1'b0;
    end
    if (conv != CONV_CAMEL && conv != CONV_PASCAL && !scan.has_letter) begin
      return scan.all_digits;
    end
    return scan.head_ok && scan.tail_ok;
  endfunction

  task automatic scan_item(input logic [CH_W-1:0] c, input bit has, input bit fin,
                           output bit gives, output bit verdict);
    logic [2:0] rule;
    gives = 1'b0;
    verdict = 1'b0;
    if (has) begin
      if (splits(conv_setting) && c == sep_for(conv_setting)) begin
        scan.name_ok    = scan.name_ok && word_passes(conv_setting);
        scan.word_start = 1'b1;
        scan.has_letter = 1'b0;
        scan.all_digits = 1'b1;
        scan.head_ok    = 1'b0;
        scan.tail_ok    = 1'b1;
        scan.first_word = 1'b0;
      end else begin
        rule = rule_for(conv_setting, scan.first_word);
        if (scan.word_start) begin
          scan.head_ok = head_fits(rule, c);
        end else begin
          scan.tail_ok = scan.tail_ok && tail_fits(rule, c);
        end
        scan.has_letter = scan.has_letter || lower_letter(c) || upper_letter(c);
        scan.all_digits = scan.all_digits && decimal_digit(c);
        scan.word_start = 1'b0;
      end
      scan.name_start = 1'b0;
    end
    if (fin) begin
      gives = 1'b1;
      if (conv_setting == CONV_NONE) begin
        verdict = 1'b1;
      end else if (conv_setting > CONV_LISP) begin
        verdict = 1'b0;
      end else begin
        verdict = scan.name_ok && word_passes(conv_setting);
      end
      scan = SCAN_IDLE;
    end
  endtask

  function automatic logic [CH_W-1:0] lower_char();
    logic [CH_W-1:0] off;
    off = CH_W'($urandom_range(0, 25));
    return CH_LO_A + off;
  endfunction

  function automatic logic [CH_W-1:0] upper_char();
    logic [CH_W-1:0] off;
    off = CH_W'($urandom_range(0, 25));
    return CH_UP_A + off;
  endfunction

  function automatic logic [CH_W-1:0] digit_char();
    logic [CH_W-1:0] off;
    off = CH_W'($urandom_range(0, 9));
    return CH_DIG_0 + off;
  endfunction

  function automatic logic [CH_W-1:0] noise_char();
    logic [CH_W-1:0] b;
    b = CH_W'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return lower_char();
      1:       return upper_char();
      2:       return digit_char();
      3:       return CH_UNDERSCORE;
      4:       return CH_HYPHEN;
      default: return b;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] tail_char(input logic [2:0] rule);
    int k;
    k = $urandom_range(0, 2);
    case (rule)
      RULE_UPPER:              return (k == 0) ? digit_char() : upper_char();
      RULE_CAMEL, RULE_PASCAL: return (k == 0) ? digit_char() :
                                      (k == 1) ? upper_char() : lower_char();
      default:                 return (k == 0) ? digit_char() : lower_char();
    endcase
  endfunction

  task automatic add_name_char(input logic [CH_W-1:0] c);
    name_buf = {name_buf, c};
  endtask

  task automatic push_char(input logic [CH_W-1:0] c, input bit has, input bit fin);
    char_item_t item;
    item = '{ch: c, has: has, fin: fin, gap: $urandom_range(0, send_gap_max)};
    char_q = {char_q, item};
    if (has || fin) begin
      stim_count++;
    end
  endtask

  task automatic push_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], 1'b1, fin && (i == s.len() - 1));
    end
  endtask

  task automatic build_word(input logic [2:0] rule);
    int tail_len;
    tail_len = $urandom_range(0, 4);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) add_name_char(digit_char());
    end else begin
      add_name_char((rule == RULE_LOWER || rule == RULE_CAMEL) ? lower_char() : upper_char());
      repeat (tail_len) add_name_char(tail_char(rule));
    end
  endtask

  task automatic build_name(input logic [CONV_W-1:0] conv);
    int pick;
    int words;
    int pos;
    name_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      return;
    end
    if (pick < 20) begin
      repeat ($urandom_range(1, 6)) add_name_char(noise_char());
      return;
    end
    words = splits(conv) ? $urandom_range(1, 4) : 1;
    for (int w = 0; w < words; w++) begin
      if (w > 0) begin
        add_name_char(sep_for(conv));
      end
      build_word(rule_for(conv, w == 0));
    end
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, name_buf.size() - 1);
      name_buf[pos] = noise_char();
    end
  endtask

  task automatic emit_name(input bit fin);
    bit trail;
    trail = fin && (name_buf.size() != 0) && ($urandom_range(0, 9) == 0);
    foreach (name_buf[i]) begin
      if ($urandom_range(0, 19) == 0) begin
        push_char(noise_char(), 1'b0, 1'b0);
      end
      push_char(name_buf[i], 1'b1, fin && !trail && (i == name_buf.size() - 1));
    end
    if (fin && (trail || name_buf.size() == 0)) begin
      push_char(noise_char(), 1'b0, 1'b1);
    end
  endtask

  task automatic set_convention(input logic [CONV_W-1:0] v);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_convention <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    conv_setting = v;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (char_q.size() != 0 || in_valid || pending_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_ch       <= '0;
      in_has_char <= 1'b0;
      in_last     <= 1'b0;
      send_wait   = 0;
    end else begin
      if (in_valid && in_ready) begin
        scan_item(in_ch, in_has_char, in_last, step_gives, step_verdict);
        if (step_gives) begin
          pending_verdicts = {pending_verdicts, step_verdict};
        end
        chars_taken++;
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && send_wait >= char_q[0].gap) begin
          next_item = char_q.pop_front();
          in_valid    <= 1'b1;
          in_ch       <= next_item.ch;
          in_has_char <= next_item.has;
          in_last     <= next_item.fin;
          send_wait   = 0;
        end else begin
          in_valid <= 1'b0;
          if (char_q.size() != 0) begin
            send_wait++;
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready     <= 1'b0;
      recv_wait     = 0;
      rx_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t unexpected verdict: expected none, actual %0b", $time, out_matches_res);
        end else begin
          expected_match = pending_verdicts.pop_front();
          if (out_matches_res !== expected_match) begin
            mismatches++;
            $display("%0t verdict mismatch: expected %0b, actual %0b",
                     $time, expected_match, out_matches_res);
          end
        end
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      if (rx_stall_seen != rx_stall_count) begin
        rx_stall_seen = rx_stall_count;
        rx_stall_left = RX_HOLD_CYCLES;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CONV_W-1:0] conv;
    int                phase_end;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed names
    send_gap_max = 2;
    set_convention(CONV_NONE);
    @(negedge clk);
    push_char(8'h00, 1'b0, 1'b1);
    push_char(8'hFF, 1'b1, 1'b1);
    drain();
    set_convention(CONV_SNAKE);
    @(negedge clk);
    push_char(8'h00, 1'b0, 1'b1);
    push_text("a_1", 1'b1);
    push_text("_a", 1'b1);
    push_text("a", 1'b0);
    push_char(8'h5F, 1'b0, 1'b0);
    push_char(8'h00, 1'b0, 1'b1);
    drain();
    set_convention(CONV_CAMEL);
    @(negedge clk);
    push_text("9", 1'b1);
    push_text("aZ", 1'b1);
    drain();
    // name left open across a convention change
    set_convention(CONV_LISP);
    @(negedge clk);
    push_text("ab-", 1'b0);
    drain();
    set_convention(CONV_LOWER);
    @(negedge clk);
    push_text("x", 1'b1);
    push_char(8'h80, 1'b1, 1'b1);
    drain();
    set_convention(4'hF);
    @(negedge clk);
    push_char(8'h00, 1'b1, 1'b1);
    drain();

    // output held off while single-character names keep coming
    set_convention(CONV_SCREAM);
    @(negedge clk);
    send_gap_max = 0;
    rx_stall_count++;
    repeat (30) push_char(upper_char(), 1'b1, 1'b1);
    drain();

    for (int p = 0; stim_count < ITEM_TARGET; p++) begin
      conv = (p < 10) ? CONV_W'(p) : ((p == 10) ? 4'hF : CONV_W'($urandom_range(1, 15)));
      send_gap_max = (p % 3 == 0) ? 0 : 8;
      recv_gap_max = (p % 4 == 1) ? 0 : 8;
      set_convention(conv);
      @(negedge clk);
      if (p == 6) begin
        rx_stall_count++;
      end
      phase_end = stim_count + PHASE_ITEMS;
      while (stim_count < phase_end) begin
        build_name(conv);
        emit_name(1'b1);
      end
      if ($urandom_range(0, 1) == 0) begin
        build_name(conv);
        emit_name(1'b0);
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (pending_verdicts.size() != 0) begin
      mismatches++;
      $display("%0t %0d expected verdicts never arrived", $time, pending_verdicts.size());
    end
    $display("covered %0d items and %0d verdicts over all ten conventions and unused codes,",
             chars_taken, verdicts_seen);
    $display("with empty names, ignored items, open names across changes and output stalls");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
